// File: rtl/ggp_pkg.sv
// Shared constants and types for the granular grain player.
`default_nettype none

package ggp_pkg;

    localparam int DELAY_DEPTH = 16384;
    localparam int ADDR_BITS   = $clog2(DELAY_DEPTH);
    localparam int SAMPLE_BITS = 16;
    localparam int LEN_BITS    = 15;
    localparam int STEP_BITS   = 16;
    localparam int PHASE_BITS  = 32;
    localparam int FRAC_BITS   = 12;
    localparam int AMP_BITS    = 16;

    // dividend width of the shared divider: start + integer phase
    localparam int DVD_BITS    = PHASE_BITS - FRAC_BITS + 1;
    localparam int CNT_BITS    = $clog2(DVD_BITS + 1);

    localparam logic [STEP_BITS-1:0] UNITY_STEP = STEP_BITS'(4096);
    localparam logic [LEN_BITS-1:0]  DEPTH_LEN  = LEN_BITS'(DELAY_DEPTH);
    localparam logic [AMP_BITS-1:0]  AMP_FULL   = AMP_BITS'(32768);

    typedef enum logic [1:0] {
        MODE_WRITE    = 2'd0,
        MODE_ACTIVATE = 2'd1,
        MODE_RENDER   = 2'd2
    } mode_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

endpackage

`default_nettype wire

// File: rtl/granular_grain_player.sv
// Granular grain player: one grain voice over a stereo delay memory.
// Write beat: stores the sample pair. Activate beat: divides only when the moved-back
// start wraps. Render beat with a grain playing: uses the one-bit-per-cycle
// shared divider (21 steps for the read address modulo, 15 for the envelope),
// and skips the envelope divide on the flat part; with no grain the mix passes through.
// Reset (aresetn low, synchronous) idles the grain; delay memory is not cleared.
`default_nettype none

module granular_grain_player (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [1:0]                          s_mode,
    input  wire logic [ggp_pkg::ADDR_BITS-1:0]       s_write_address,
    input  wire logic signed [ggp_pkg::SAMPLE_BITS-1:0] s_left_in,
    input  wire logic signed [ggp_pkg::SAMPLE_BITS-1:0] s_right_in,
    input  wire logic [ggp_pkg::ADDR_BITS-1:0]       s_start_pos,
    input  wire logic [ggp_pkg::LEN_BITS-1:0]        s_grain_length,
    input  wire logic [ggp_pkg::STEP_BITS-1:0]       s_pitch_step,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [ggp_pkg::SAMPLE_BITS-1:0]   m_left_out,
    output logic signed [ggp_pkg::SAMPLE_BITS-1:0]   m_right_out,
    output logic                                     m_grain_active,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ggp_pkg::LEN_BITS-1:0]        cfg_buffer_length
);

    localparam int SB  = ggp_pkg::SAMPLE_BITS;
    localparam int AB  = ggp_pkg::ADDR_BITS;
    localparam int LB  = ggp_pkg::LEN_BITS;
    localparam int DB  = ggp_pkg::DVD_BITS;
    localparam int CB  = ggp_pkg::CNT_BITS;
    localparam int PB  = ggp_pkg::PHASE_BITS;
    localparam int FB  = ggp_pkg::FRAC_BITS;
    localparam int MB  = SB + ggp_pkg::AMP_BITS + 1;   // product width
    localparam int QB  = MB - 15;                       // product >>> 15
    localparam int XB  = LB + 2;                        // 3 * count
    localparam int PRB = ggp_pkg::STEP_BITS + LB;       // activation product

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACT_SUB,
        S_ACT_DIV,
        S_RND_ADDR,
        S_RND_AMP,
        S_RND_MUL,
        S_RND_SUM,
        S_OUT
    } state_t;

    state_t                     state_reg;

    // grain state
    logic                       active_reg;
    logic [AB-1:0]              start_position_reg;
    logic [PB-1:0]              read_phase_reg;
    logic [LB-1:0]              sample_count_reg;
    logic [LB-1:0]              length_held_reg;
    logic [ggp_pkg::STEP_BITS-1:0] step_held_reg;
    logic [LB-1:0]              buffer_length_reg;

    // activation scratch
    logic [PRB-1:0]             act_prod_reg;
    logic [AB-1:0]              act_start_reg;

    // render scratch
    ggp_pkg::sample_t           mix_l_reg, mix_r_reg;
    logic                       amp_full_reg;
    logic signed [MB-1:0]       prod_l_reg, prod_r_reg;
    ggp_pkg::sample_t           res_l_reg, res_r_reg;
    logic                       res_act_reg;

    // output register
    logic                       m_valid_reg;
    ggp_pkg::sample_t           m_left_reg, m_right_reg;
    logic                       m_active_reg;

    // shared restoring divider, one quotient bit per cycle
    logic [LB-1:0]              div_rem_reg, div_rem_next;
    logic [DB-1:0]              div_dvd_reg, div_dvd_next;
    logic [LB-1:0]              div_quo_reg, div_quo_next;
    logic [LB-1:0]              div_divisor_reg;
    logic [CB-1:0]              div_cnt_reg;
    logic [LB:0]                div_trial;
    logic                       div_ge;

    // delay memory, {left, right} per entry
    logic [2*SB-1:0]            delay_mem [ggp_pkg::DELAY_DEPTH];
    logic [2*SB-1:0]            mem_q_reg;
    logic                       wr_en, rd_en;

    // combinational helpers
    logic                       s_fire;
    logic                       render_live;
    logic [LB-1:0]              bl_eff;
    logic [DB-1:0]              addr_sum;
    logic [ggp_pkg::STEP_BITS-1:0] step_excess;
    logic signed [DB-1:0]       act_pos;
    logic [DB-1:0]              act_mag;
    logic [XB-1:0]              tri_count, tri_rest, two_len;
    logic [LB-1:0]              rest;
    logic [ggp_pkg::AMP_BITS-1:0] amp;
    ggp_pkg::sample_t           mem_l, mem_r;
    logic signed [QB-1:0]       scaled_l, scaled_r;
    logic [LB-1:0]              count_inc;

    function automatic ggp_pkg::sample_t sat_add(ggp_pkg::sample_t a,
                                                 logic signed [QB-1:0] b);
        logic signed [QB:0] s;
        logic signed [QB:0] hi;
        logic signed [QB:0] lo;
        hi = (QB+1)'({1'b0, {(SB-1){1'b1}}});
        lo = -hi - (QB+1)'(1);
        s  = (QB+1)'(a) + (QB+1)'(b);
        if (s > hi) begin
            return SB'(hi);
        end else if (s < lo) begin
            return SB'(lo);
        end
        return SB'(s);
    endfunction

    assign s_ready        = (state_reg == S_IDLE);
    assign cfg_ready      = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_left_out     = m_left_reg;
    assign m_right_out    = m_right_reg;
    assign m_grain_active = m_active_reg;

    assign s_fire  = s_valid && s_ready;
    assign wr_en   = s_fire && (s_mode == ggp_pkg::MODE_WRITE);
    assign rd_en   = (state_reg == S_RND_ADDR) && (div_cnt_reg == '0);

    always_comb begin
        div_trial    = {div_rem_reg, div_dvd_reg[DB-1]};
        div_ge       = (div_trial >= {1'b0, div_divisor_reg});
        div_rem_next = div_ge ? LB'(div_trial - {1'b0, div_divisor_reg})
                              : div_trial[LB-1:0];
        div_quo_next = {div_quo_reg[LB-2:0], div_ge};
        div_dvd_next = {div_dvd_reg[DB-2:0], 1'b0};
    end

    always_comb begin
        render_live = active_reg && (sample_count_reg < length_held_reg);
        bl_eff      = ((buffer_length_reg == '0) || (buffer_length_reg > ggp_pkg::DEPTH_LEN))
                      ? ggp_pkg::DEPTH_LEN : buffer_length_reg;
        addr_sum    = DB'(start_position_reg) + DB'(read_phase_reg[PB-1:FB]);
        step_excess = s_pitch_step - ggp_pkg::UNITY_STEP;
        act_pos     = $signed(DB'(act_start_reg)) - $signed(DB'(act_prod_reg[PRB-1:FB]));
        act_mag     = DB'(-act_pos);
        rest        = length_held_reg - sample_count_reg;
        tri_count   = XB'({sample_count_reg, 1'b0}) + XB'(sample_count_reg);
        tri_rest    = XB'({rest, 1'b0}) + XB'(rest);
        two_len     = XB'({length_held_reg, 1'b0});
        amp         = amp_full_reg ? ggp_pkg::AMP_FULL : ggp_pkg::AMP_BITS'(div_quo_reg);
        mem_l       = mem_q_reg[2*SB-1:SB];
        mem_r       = mem_q_reg[SB-1:0];
        scaled_l    = prod_l_reg[MB-1:15];
        scaled_r    = prod_r_reg[MB-1:15];
        count_inc   = sample_count_reg + LB'(1);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            delay_mem[s_write_address] <= {s_left_in, s_right_in};
        end
        if (rd_en) begin
            mem_q_reg <= delay_mem[div_rem_reg[AB-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            active_reg         <= 1'b0;
            start_position_reg <= '0;
            read_phase_reg     <= '0;
            sample_count_reg   <= '0;
            length_held_reg    <= '0;
            step_held_reg      <= ggp_pkg::UNITY_STEP;
            buffer_length_reg  <= ggp_pkg::DEPTH_LEN;
            div_cnt_reg        <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                buffer_length_reg <= cfg_buffer_length;
            end
            // S_OUT owns the output register while it loads
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            if (div_cnt_reg != '0) begin
                div_rem_reg <= div_rem_next;
                div_dvd_reg <= div_dvd_next;
                div_quo_reg <= div_quo_next;
                div_cnt_reg <= div_cnt_reg - CB'(1);
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        unique case (s_mode)
                            ggp_pkg::MODE_ACTIVATE: begin
                                act_start_reg    <= s_start_pos;
                                act_prod_reg     <= (s_pitch_step > ggp_pkg::UNITY_STEP)
                                                    ? PRB'(step_excess) * PRB'(s_grain_length)
                                                    : '0;
                                length_held_reg  <= s_grain_length;
                                step_held_reg    <= s_pitch_step;
                                read_phase_reg   <= '0;
                                sample_count_reg <= '0;
                                active_reg       <= 1'b1;
                                state_reg        <= S_ACT_SUB;
                            end
                            ggp_pkg::MODE_RENDER: begin
                                mix_l_reg <= s_left_in;
                                mix_r_reg <= s_right_in;
                                if (render_live) begin
                                    div_rem_reg     <= '0;
                                    div_dvd_reg     <= addr_sum;
                                    div_divisor_reg <= bl_eff;
                                    div_cnt_reg     <= CB'(DB);
                                    state_reg       <= S_RND_ADDR;
                                end else begin
                                    // no grain: mix passes through
                                    active_reg  <= 1'b0;
                                    res_l_reg   <= s_left_in;
                                    res_r_reg   <= s_right_in;
                                    res_act_reg <= 1'b0;
                                    state_reg   <= S_OUT;
                                end
                            end
                            default: begin
                                // write handled by the memory port; other codes do nothing
                            end
                        endcase
                    end
                end
                S_ACT_SUB: begin
                    if (act_pos < 0 && length_held_reg != '0) begin
                        div_rem_reg     <= '0;
                        div_dvd_reg     <= act_mag;
                        div_divisor_reg <= length_held_reg;
                        div_cnt_reg     <= CB'(DB);
                        state_reg       <= S_ACT_DIV;
                    end else begin
                        start_position_reg <= act_pos[AB-1:0];
                        state_reg          <= S_IDLE;
                    end
                end
                S_ACT_DIV: begin
                    if (div_cnt_reg == '0) begin
                        // (-m) mod L from m mod L
                        start_position_reg <= (div_rem_reg == '0) ? '0
                                              : AB'(length_held_reg - div_rem_reg);
                        state_reg          <= S_IDLE;
                    end
                end
                S_RND_ADDR: begin
                    if (div_cnt_reg == '0) begin
                        // memory read issued this edge from the remainder
                        if (tri_count < XB'(length_held_reg)) begin
                            amp_full_reg    <= 1'b0;
                            div_rem_reg     <= LB'(tri_count);
                            div_dvd_reg     <= '0;
                            div_quo_reg     <= '0;
                            div_divisor_reg <= length_held_reg;
                            div_cnt_reg     <= CB'(15);
                        end else if (tri_count > two_len) begin
                            amp_full_reg    <= 1'b0;
                            div_rem_reg     <= LB'(tri_rest);
                            div_dvd_reg     <= '0;
                            div_quo_reg     <= '0;
                            div_divisor_reg <= length_held_reg;
                            div_cnt_reg     <= CB'(15);
                        end else begin
                            amp_full_reg <= 1'b1;
                        end
                        state_reg <= S_RND_AMP;
                    end
                end
                S_RND_AMP: begin
                    if (div_cnt_reg == '0) begin
                        state_reg <= S_RND_MUL;
                    end
                end
                S_RND_MUL: begin
                    prod_l_reg <= MB'(mem_l) * $signed({1'b0, amp});
                    prod_r_reg <= MB'(mem_r) * $signed({1'b0, amp});
                    state_reg  <= S_RND_SUM;
                end
                S_RND_SUM: begin
                    res_l_reg        <= sat_add(mix_l_reg, scaled_l);
                    res_r_reg        <= sat_add(mix_r_reg, scaled_r);
                    res_act_reg      <= (count_inc < length_held_reg);
                    active_reg       <= (count_inc < length_held_reg);
                    read_phase_reg   <= read_phase_reg + PB'(step_held_reg);
                    sample_count_reg <= count_inc;
                    state_reg        <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_left_reg   <= res_l_reg;
                        m_right_reg  <= res_r_reg;
                        m_active_reg <= res_act_reg;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // divider only runs inside the states that wait on it
    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_cnt_reg != '0) |-> (state_reg == S_ACT_DIV || state_reg == S_RND_ADDR
                                 || state_reg == S_RND_AMP))
        else $error("divider busy outside a divide state");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_cnt_reg != '0) |-> (div_divisor_reg != '0))
        else $error("divide by zero");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (sample_count_reg <= length_held_reg))
        else $error("sample count past grain length");

    a_render_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_mode == ggp_pkg::MODE_RENDER) |=> (state_reg != S_IDLE))
        else $error("render beat produced no work");

    a_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (div_rem_reg < bl_eff))
        else $error("read address beyond buffer length");

endmodule

`default_nettype wire
